/* rtl/tso_pkg.sv */
// Shared codes and types for the three-stacks word store.
package tso_pkg;

  localparam int WORD_W  = 32;
  localparam int DEPTH_W = 7;

  // Action codes
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  // Stack select codes
  localparam logic [1:0] SEL_BOTTOM = 2'd0;
  localparam logic [1:0] SEL_MIDDLE = 2'd1;
  localparam logic [1:0] SEL_TOP    = 2'd2;
  localparam logic [1:0] SEL_NONE   = 2'd3;   // selector with no stack behind it

  // Status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

  // Command broadcast along the row of cells
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic wr_en;
  } cell_cmd_t;

endpackage

/* rtl/tso_cell.sv */
// One word cell of the store: takes a neighbour's word on a middle-stack shift, or a written word.
module tso_cell #(
  parameter int STORE_WORDS = 64,
  parameter int CELL_IDX    = 0
) (
  input  logic                                    clk,
  input  tso_pkg::cell_cmd_t                      cmd,
  input  logic [$clog2(STORE_WORDS+1)-1:0]        mid_lo,
  input  logic [$clog2(STORE_WORDS+1)-1:0]        mid_hi,
  input  logic [$clog2(STORE_WORDS)-1:0]          wr_idx,
  input  logic [$clog2(STORE_WORDS)-1:0]          rd_idx,
  input  logic [tso_pkg::WORD_W-1:0]              wr_data,
  input  logic [tso_pkg::WORD_W-1:0]              lower_word,
  input  logic [tso_pkg::WORD_W-1:0]              upper_word,
  output logic [tso_pkg::WORD_W-1:0]              word_o,
  output logic [tso_pkg::WORD_W-1:0]              rd_word
);
  import tso_pkg::*;

  localparam int CNT_W = $clog2(STORE_WORDS + 1);
  localparam int IDX_W = $clog2(STORE_WORDS);
  localparam bit HAS_LOWER = (CELL_IDX > 0);
  localparam int UP_SRC = (CELL_IDX > 0) ? CELL_IDX - 1 : 0;
  localparam int DN_SRC = CELL_IDX + 1;
  localparam logic [CNT_W-1:0] UP_SRC_C = CNT_W'(UP_SRC);
  localparam logic [CNT_W-1:0] DN_SRC_C = CNT_W'(DN_SRC);
  localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);

  logic [WORD_W-1:0] word_r;
  logic [WORD_W-1:0] word_nxt;
  logic              up_take;
  logic              dn_take;

  // Take the neighbour's word when that neighbour lies inside the middle stack
  assign up_take = cmd.shift_up && HAS_LOWER && (UP_SRC_C >= mid_lo) && (UP_SRC_C < mid_hi);
  assign dn_take = cmd.shift_down && (DN_SRC_C >= mid_lo) && (DN_SRC_C < mid_hi);

  always_comb begin
    if (up_take) begin
      word_nxt = lower_word;
    end else if (dn_take) begin
      word_nxt = upper_word;
    end else if (cmd.wr_en && (wr_idx == MY_IDX)) begin
      word_nxt = wr_data;
    end else begin
      word_nxt = word_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

  // Gated read: only the addressed cell drives its word
  assign rd_word = (rd_idx == MY_IDX) ? word_r : '0;
  assign word_o  = word_r;

endmodule

/* rtl/three_stacks_one_array.sv */
// Top level: three stacks sharing one row of word cells, with control and result register.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  in      | in_valid  | in_stall  | in_action, in_stack_select, in_push_value
//  out     | out_valid | out_stall | out_pop_value, out_status, out_depth
//
// Each request is handled in the row of cells: any middle-stack shift, the write
// and the pop read all happen there at the edge that accepts it. The result register
// then holds the answer, and the input stalls until it is taken, so no new request
// is taken while a result is pending. Reset (rst_n low, synchronous) clears the
// counts and places the middle stack at a third of the store; the word cells
// themselves are not cleared.
module three_stacks_one_array #(
  parameter int STORE_WORDS = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_action,
  input  logic [1:0]                        in_stack_select,
  input  logic signed [tso_pkg::WORD_W-1:0] in_push_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tso_pkg::WORD_W-1:0] out_pop_value,
  output logic [1:0]                        out_status,
  output logic [tso_pkg::DEPTH_W-1:0]       out_depth
);
  import tso_pkg::*;

  localparam int CNT_W = $clog2(STORE_WORDS + 1);
  localparam int IDX_W = $clog2(STORE_WORDS);
  localparam logic [CNT_W-1:0] N_C    = CNT_W'(STORE_WORDS);
  localparam logic [CNT_W-1:0] MS_RST = CNT_W'(STORE_WORDS / 3);
  localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);

  // Stack bookkeeping
  logic [CNT_W-1:0] bot_r, bot_nxt;
  logic [CNT_W-1:0] ms_r, ms_nxt;
  logic [CNT_W-1:0] mc_r, mc_nxt;
  logic [CNT_W-1:0] top_r, top_nxt;
  logic [CNT_W-1:0] mid_end;
  logic             bottom_hits;
  logic             top_hits;
  logic             full;
  logic             accept;

  // Cell row control
  cell_cmd_t        cmd;
  logic [CNT_W-1:0] wr_at;
  logic [CNT_W-1:0] rd_at;
  logic [WORD_W-1:0] cell_word [STORE_WORDS];
  logic [WORD_W-1:0] cell_rd   [STORE_WORDS];
  logic [WORD_W-1:0] rd_data;

  // Result
  logic              pop_ok;
  logic [1:0]        stat;
  logic [CNT_W-1:0]  depth_cnt;
  logic [CNT_W+DEPTH_W-1:0] depth_ext;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] out_pop_r, out_pop_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [DEPTH_W-1:0] out_depth_r, out_depth_nxt;

  assign in_stall    = out_valid_r;
  assign accept      = in_valid && !in_stall;
  assign mid_end     = ms_r + mc_r;
  assign bottom_hits = (bot_r == ms_r);
  assign top_hits    = (mid_end == (N_C - top_r));
  assign full        = bottom_hits && top_hits;

  // Request decode: counts, shift, write and read addresses
  always_comb begin
    cmd     = '0;
    wr_at   = '0;
    rd_at   = '0;
    bot_nxt = bot_r;
    ms_nxt  = ms_r;
    mc_nxt  = mc_r;
    top_nxt = top_r;
    stat    = STAT_OK;
    pop_ok  = 1'b0;
    if (accept) begin
      case (in_stack_select)
        SEL_BOTTOM: begin
          if (in_action == ACT_PUSH) begin
            if (full) begin
              stat = STAT_OVERFLOW;
            end else begin
              if (bottom_hits) begin
                cmd.shift_up = 1'b1;
                ms_nxt       = ms_r + ONE_C;
              end
              cmd.wr_en = 1'b1;
              wr_at     = bot_r;
              bot_nxt   = bot_r + ONE_C;
            end
          end else if (bot_r == '0) begin
            stat = STAT_UNDERFLOW;
          end else begin
            bot_nxt = bot_r - ONE_C;
            rd_at   = bot_r - ONE_C;
            pop_ok  = 1'b1;
          end
        end
        SEL_MIDDLE: begin
          if (in_action == ACT_PUSH) begin
            if (full) begin
              stat = STAT_OVERFLOW;
            end else begin
              if (top_hits && (ms_r != '0)) begin
                cmd.shift_down = 1'b1;
                ms_nxt         = ms_r - ONE_C;
                wr_at          = mid_end - ONE_C;
              end else begin
                wr_at = mid_end;
              end
              cmd.wr_en = 1'b1;
              mc_nxt    = mc_r + ONE_C;
            end
          end else if (mc_r == '0) begin
            stat = STAT_UNDERFLOW;
          end else begin
            mc_nxt = mc_r - ONE_C;
            rd_at  = mid_end - ONE_C;
            pop_ok = 1'b1;
          end
        end
        SEL_TOP: begin
          if (in_action == ACT_PUSH) begin
            if (full) begin
              stat = STAT_OVERFLOW;
            end else begin
              if (top_hits && (ms_r != '0)) begin
                cmd.shift_down = 1'b1;
                ms_nxt         = ms_r - ONE_C;
              end
              cmd.wr_en = 1'b1;
              wr_at     = N_C - top_r - ONE_C;
              top_nxt   = top_r + ONE_C;
            end
          end else if (top_r == '0) begin
            stat = STAT_UNDERFLOW;
          end else begin
            rd_at   = N_C - top_r;
            top_nxt = top_r - ONE_C;
            pop_ok  = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Row of word cells
  for (genvar g = 0; g < STORE_WORDS; g++) begin : g_cell
    logic [WORD_W-1:0] lower_w;
    logic [WORD_W-1:0] upper_w;
    if (g == 0) begin : g_lo_end
      assign lower_w = '0;
    end else begin : g_lo_mid
      assign lower_w = cell_word[g-1];
    end
    if (g == STORE_WORDS - 1) begin : g_hi_end
      assign upper_w = '0;
    end else begin : g_hi_mid
      assign upper_w = cell_word[g+1];
    end
    tso_cell #(
      .STORE_WORDS (STORE_WORDS),
      .CELL_IDX    (g)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .mid_lo     (ms_r),
      .mid_hi     (mid_end),
      .wr_idx     (wr_at[IDX_W-1:0]),
      .rd_idx     (rd_at[IDX_W-1:0]),
      .wr_data    (in_push_value),
      .lower_word (lower_w),
      .upper_word (upper_w),
      .word_o     (cell_word[g]),
      .rd_word    (cell_rd[g])
    );
  end

  // Collect the one addressed word
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < STORE_WORDS; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

  // Depth of the selected stack after the request, low bits only
  always_comb begin
    case (in_stack_select)
      SEL_BOTTOM: depth_cnt = bot_nxt;
      SEL_MIDDLE: depth_cnt = mc_nxt;
      SEL_TOP:    depth_cnt = top_nxt;
      default:    depth_cnt = '0;
    endcase
    depth_ext = {{DEPTH_W{1'b0}}, depth_cnt};
  end

  // Result register
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_pop_nxt    = out_pop_r;
    out_status_nxt = out_status_r;
    out_depth_nxt  = out_depth_r;
    if (accept) begin
      out_valid_nxt  = 1'b1;
      out_pop_nxt    = pop_ok ? rd_data : '0;
      out_status_nxt = stat;
      out_depth_nxt  = depth_ext[DEPTH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bot_r       <= '0;
      ms_r        <= MS_RST;
      mc_r        <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      bot_r       <= bot_nxt;
      ms_r        <= ms_nxt;
      mc_r        <= mc_nxt;
      top_r       <= top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pop_r    <= out_pop_nxt;
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_pop_value = out_pop_r;
  assign out_status    = out_status_r;
  assign out_depth     = out_depth_r;

  // Stacks keep their order and never overrun the store
  a_layout : assert property (@(posedge clk) disable iff (!rst_n)
    (bot_r <= ms_r) && (({1'b0, mid_end} + {1'b0, top_r}) <= {1'b0, N_C}))
    else $error("stack layout broken");

  // Every accepted request yields a pending result
  a_result : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted request without result");

  // An overflowing push leaves all bookkeeping untouched
  a_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_action == ACT_PUSH) && full && (in_stack_select != SEL_NONE)) |=>
      ($stable(bot_r) && $stable(ms_r) && $stable(mc_r) && $stable(top_r)))
    else $error("overflow changed state");

endmodule
